FILE: design/afpm_pkg.sv
package afpm_pkg;

    // position and counter widths
    localparam int POS_BITS  = 41;
    localparam int CNT_BITS  = 40;
    localparam int FRAG_BITS = 16;
    localparam int CH_BITS   = 4;

    // configuration port
    localparam int APB_AW = 5;
    localparam int APB_DW = 64;

    localparam logic [1:0] REG_FRAG_SIZE = 2'd0;
    localparam logic [1:0] REG_CHANNELS  = 2'd1;
    localparam logic [1:0] REG_START_POS = 2'd2;

    localparam logic [FRAG_BITS-1:0] FRAG_SIZE_RESET = 16'd4800;
    localparam logic [CH_BITS-1:0]   CHANNELS_RESET  = 4'd2;

    // input item kinds
    typedef enum logic [1:0] {
        CMD_FRAME   = 2'd0,
        CMD_QUERY   = 2'd1,
        CMD_RESTART = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    // control sequencer
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_FIN
    } t_state;

endpackage

FILE: design/afpm_ram.sv
module afpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/afpm_lane.sv
module afpm_lane #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_clr,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic [SAMPLE_BITS-1:0]        o_peak_next
);

    logic [SAMPLE_BITS-1:0] r_peak;
    logic [SAMPLE_BITS-1:0] mag;

    // magnitude; the most negative code maps to its unsigned weight
    always_comb begin
        mag = i_sample[SAMPLE_BITS-1] ? (~i_sample + 1'b1) : i_sample;
        o_peak_next = (i_en && (mag > r_peak)) ? mag : r_peak;
    end

    // running peak, cleared when the fragment closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_peak <= '0;
        end else if (i_en) begin
            r_peak <= o_peak_next;
        end
    end

endmodule

FILE: design/audio_fragment_peak_meter.sv
// Per-channel fragment peak meter with a history ring. Frame items (tuser 0) update one
// running-peak lane per channel; when a fragment closes (the programmed number of frames
// or tlast) the lane peaks and the position just past the fragment go into the ring
// memory. A query item (tuser 1) walks the ring from the current read slot, reading each
// slot through the registered memory read in a read state and then a compare state; it
// reads at most RING_DEPTH + 1 slots, and the result item goes to the output register,
// which may first have to wait until that register is free, before the next item is taken.
// A restart item (tuser 2), and reset itself, start a clearing pass that writes every
// ring entry, one per cycle, during which no item is taken; configuration writes are
// taken at any time.
module audio_fragment_peak_meter #(
    parameter int RING_DEPTH   = 64,
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 24,
    localparam int IN_DW  = ((MAX_CHANNELS * SAMPLE_BITS + afpm_pkg::POS_BITS + 7) / 8) * 8,
    localparam int OUT_DW =
        ((MAX_CHANNELS + MAX_CHANNELS * SAMPLE_BITS + afpm_pkg::POS_BITS + 7) / 8) * 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input items
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [IN_DW-1:0]            i_s_tdata,  // sample_0..sample_N-1, query_position
    input  logic [1:0]                  i_s_tuser,  // cmd
    input  logic                        i_s_tlast,  // buffer_end
    // result items
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [OUT_DW-1:0]           o_m_tdata,  // over_mask, peak_0..peak_N-1, entry_position
    output logic                        o_m_tuser,  // updated
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [afpm_pkg::APB_AW-1:0] paddr,
    input  logic [afpm_pkg::APB_DW-1:0] pwdata,
    output logic [afpm_pkg::APB_DW-1:0] prdata,
    output logic                        pready
);

    import afpm_pkg::*;

    localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int PW = MAX_CHANNELS * SAMPLE_BITS;
    localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
    localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = SAMPLE_BITS'(1) << (SAMPLE_BITS - 4);

    t_state r_state, n_state;

    logic [FRAG_BITS-1:0]       r_frag_size;
    logic [CH_BITS-1:0]         r_channels;
    logic [CNT_BITS-1:0]        r_start_pos;

    logic [AW-1:0]              r_wslot, r_rslot, r_start_slot, r_clr;
    logic                       r_lapped, r_back;
    logic signed [POS_BITS-1:0] r_target, r_last_rep;
    logic [FRAG_BITS-1:0]       r_frames;
    logic [CNT_BITS-1:0]        r_frame_cnt;
    logic                       r_out_valid, r_out_upd;
    logic [OUT_DW-1:0]          r_out_data;

    t_cmd                       cmd;
    logic                       s_acc, frame_fire, query_fire, restart_fire, close;
    logic [FRAG_BITS-1:0]       limit, frames_inc;
    logic [CNT_BITS-1:0]        cnt_inc;
    logic [MAX_CHANNELS-1:0]    active;
    logic [PW-1:0]              lane_peaks, close_peaks, sel_peaks;
    logic [MAX_CHANNELS-1:0]    over_mask;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr, slot_inc, slot_dec;
    logic [PW-1:0]              ram_wpeak, rd_peak;
    logic [POS_BITS-1:0]        ram_wpos, rd_pos_raw;
    logic signed [POS_BITS-1:0] rd_pos;
    logic                       pos_lt, pos_gt, out_free, cfg_we;

    // configuration port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frag_size <= FRAG_SIZE_RESET;
            r_channels  <= CHANNELS_RESET;
            r_start_pos <= '0;
        end else if (cfg_we) begin
            case (paddr[4:3])
                REG_FRAG_SIZE: r_frag_size <= pwdata[FRAG_BITS-1:0];
                REG_CHANNELS:  r_channels  <= pwdata[CH_BITS-1:0];
                REG_START_POS: r_start_pos <= pwdata[CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            REG_FRAG_SIZE: prdata = APB_DW'(r_frag_size);
            REG_CHANNELS:  prdata = APB_DW'(r_channels);
            REG_START_POS: prdata = APB_DW'(r_start_pos);
            default:       prdata = '0;
        endcase
    end

    // item decode
    assign cmd          = t_cmd'(i_s_tuser);
    assign s_acc        = i_s_tvalid && o_s_tready;
    assign frame_fire   = s_acc && (cmd == CMD_FRAME);
    assign query_fire   = s_acc && (cmd == CMD_QUERY);
    assign restart_fire = s_acc && (cmd == CMD_RESTART);

    assign limit      = (r_frag_size == '0) ? FRAG_BITS'(1) : r_frag_size;
    assign frames_inc = r_frames + 1'b1;
    assign cnt_inc    = r_frame_cnt + 1'b1;
    assign close      = frame_fire && ((frames_inc >= limit) || i_s_tlast);

    // peak lanes, one per channel
    for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_lane
        assign active[c] = (CH_BITS'(c) < r_channels);

        afpm_lane #(
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (frame_fire && active[c]),
            .i_clr       (close || restart_fire),
            .i_sample    (i_s_tdata[c*SAMPLE_BITS +: SAMPLE_BITS]),
            .o_peak_next (lane_peaks[c*SAMPLE_BITS +: SAMPLE_BITS])
        );

        // merge: inactive lanes store and report zero
        assign close_peaks[c*SAMPLE_BITS +: SAMPLE_BITS] =
            active[c] ? lane_peaks[c*SAMPLE_BITS +: SAMPLE_BITS] : '0;
        assign sel_peaks[c*SAMPLE_BITS +: SAMPLE_BITS] =
            active[c] ? rd_peak[c*SAMPLE_BITS +: SAMPLE_BITS] : '0;
        assign over_mask[c] = (sel_peaks[c*SAMPLE_BITS +: SAMPLE_BITS] > FULL_SCALE);
    end

    // ring memories
    assign ram_we    = close || (r_state == ST_CLEAR);
    assign ram_waddr = (r_state == ST_CLEAR) ? r_clr : r_wslot;
    assign ram_wpeak = (r_state == ST_CLEAR) ? '0 : close_peaks;
    assign ram_wpos  = (r_state == ST_CLEAR) ? '1 : {1'b0, cnt_inc};

    afpm_ram #(
        .WIDTH (PW),
        .DEPTH (RING_DEPTH)
    ) u_peak_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wpeak),
        .i_raddr (r_rslot),
        .o_rdata (rd_peak)
    );

    afpm_ram #(
        .WIDTH (POS_BITS),
        .DEPTH (RING_DEPTH)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wpos),
        .i_raddr (r_rslot),
        .o_rdata (rd_pos_raw)
    );

    // ring walk compare
    assign rd_pos   = signed'(rd_pos_raw);
    assign pos_lt   = (rd_pos < r_target);
    assign pos_gt   = (rd_pos > r_target);
    assign slot_inc = (r_rslot == LAST_SLOT) ? '0 : r_rslot + 1'b1;
    assign slot_dec = (r_rslot == '0) ? LAST_SLOT : r_rslot - 1'b1;
    assign out_free = !r_out_valid || i_m_tready;

    function automatic logic [AW-1:0] slot_inc_w(input logic [AW-1:0] s);
        slot_inc_w = (s == LAST_SLOT) ? '0 : s + 1'b1;
    endfunction

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr == LAST_SLOT) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (query_fire) n_state = ST_READ;
                else if (restart_fire) n_state = ST_CLEAR;
            end
            ST_READ: n_state = ST_CMP;
            ST_CMP: begin
                if (r_back) n_state = ST_FIN;
                else if ((pos_lt && !r_lapped) || pos_gt) n_state = ST_READ;
                else n_state = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_s_tready = (r_state == ST_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // ring pointers, fragment count and walk state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wslot      <= '0;
            r_rslot      <= '0;
            r_start_slot <= '0;
            r_clr        <= '0;
            r_lapped     <= 1'b0;
            r_back       <= 1'b0;
            r_frames     <= '0;
            r_frame_cnt  <= '0;
            r_last_rep   <= '0;
        end else begin
            if (r_state == ST_CLEAR) begin
                r_clr <= (r_clr == LAST_SLOT) ? '0 : r_clr + 1'b1;
            end
            if (frame_fire) begin
                r_frame_cnt <= cnt_inc;
                r_frames    <= close ? '0 : frames_inc;
                if (close) r_wslot <= slot_inc_w(r_wslot);
            end
            if (restart_fire) begin
                r_wslot     <= '0;
                r_rslot     <= '0;
                r_clr       <= '0;
                r_frames    <= '0;
                r_frame_cnt <= r_start_pos;
                r_last_rep  <= '0;
            end
            if (query_fire) begin
                r_start_slot <= r_rslot;
                r_lapped     <= 1'b0;
                r_back       <= 1'b0;
            end
            if ((r_state == ST_CMP) && !r_back) begin
                if (pos_lt && !r_lapped) begin
                    r_rslot  <= slot_inc;
                    r_lapped <= (slot_inc == r_start_slot);
                end else if (pos_gt) begin
                    r_rslot <= slot_dec;
                    r_back  <= 1'b1;
                end
            end
            if ((r_state == ST_FIN) && out_free) begin
                r_last_rep <= rd_pos;
            end
        end
    end

    // query target
    always_ff @(posedge i_clk) begin
        if (query_fire) begin
            r_target <= signed'(i_s_tdata[PW +: POS_BITS]);
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_FIN) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_FIN) && out_free) begin
            r_out_upd  <= (r_last_rep != rd_pos);
            r_out_data <= OUT_DW'({rd_pos_raw, sel_peaks, over_mask});
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_upd;

endmodule

FILE: design/afpm_checker.sv
module afpm_checker #(
    parameter int MAX_CHANNELS = 8,
    parameter int SAMPLE_BITS  = 24,
    localparam int OUT_DW =
        ((MAX_CHANNELS + MAX_CHANNELS * SAMPLE_BITS + afpm_pkg::POS_BITS + 7) / 8) * 8
) (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_s_tvalid,
    input logic                        o_s_tready,
    input logic [1:0]                  i_s_tuser,
    input logic                        o_m_tvalid,
    input logic                        i_m_tready,
    input logic [OUT_DW-1:0]           o_m_tdata,
    input logic                        o_m_tuser
);

    import afpm_pkg::*;

    localparam int PW = MAX_CHANNELS * SAMPLE_BITS;

    logic s_acc;
    assign s_acc = i_s_tvalid && o_s_tready;

    // a stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result item changed while stalled");

    // an empty entry carries no peaks and no over bits
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[MAX_CHANNELS + PW +: POS_BITS] == '1)
        |-> (o_m_tdata[PW + MAX_CHANNELS - 1:0] == '0))
        else $error("empty entry reported nonzero peaks");

    // restart starts the clearing pass
    a_restart_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && (t_cmd'(i_s_tuser) == CMD_RESTART) |=> !o_s_tready)
        else $error("item taken during ring clear");

    // a query walks the ring before the next item
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc && (t_cmd'(i_s_tuser) == CMD_QUERY) |=> !o_s_tready ##1 !o_s_tready)
        else $error("item taken during ring walk");

endmodule

bind audio_fragment_peak_meter afpm_checker #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .SAMPLE_BITS  (SAMPLE_BITS)
) u_afpm_checker (.*);
